[design/ksl_pkg.sv]
// ksl_pkg: shared types and constants for the keyed sequential list unit.
// Holds operation and status codes, sequencer states and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ksl_pkg;

	localparam int OP_W       = 2;
	localparam int POS_W      = 7;
	localparam int STATUS_W   = 3;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_UPDATE = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_POS   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_FINAL,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[design/ksl_store.sv]
// ksl_store: entry memory of the keyed sequential list, one write and one read port.
// Read data, read index and read-valid are registered the cycle after the request.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ksl_store #(
	parameter int DEPTH  = 64,
	parameter int WORD_W = 72
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WORD_W-1:0]        wr_data,
	output logic                          rd_vld,
	output logic [$clog2(DEPTH)-1:0]      rd_idx,
	output logic [WORD_W-1:0]             rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_idx_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		rd_idx_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
		end
	end

	assign rd_vld  = rd_vld_q;
	assign rd_idx  = rd_idx_q;
	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[design/keyed_sequential_list_unit.sv]
// keyed_sequential_list_unit: ordered list of up to DEPTH keyed entries with
// lookup, insert at position, update and delete. Uses ksl_pkg and ksl_store.
//
// Usage: a request (req_type, key, position, payload) transfers on the input
// channel when in_valid is high and in_stall is low. Each request gives exactly
// one result (status, found_position, found_payload, entry_count) on the output
// channel, which transfers when out_valid is high and out_stall is low.
// One request is handled at a time; in_stall is high from the transfer until
// the result is moved into the output register.
// Sequence: the key scan reads one entry per cycle through the single memory
// read port and stops early on a hit. An insert or delete then moves each
// later entry through the same port, one per cycle, and waits for the last
// read to drain. The final write follows, and the result is then loaded into
// the output register once that register is free.
// The finished result sits in an output register; while the receiver stalls
// it holds, and a new request may be taken and worked on meanwhile.
// Reset empties the list at once (count cleared); no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module keyed_sequential_list_unit #(
	parameter int DEPTH     = 64,
	parameter int KEY_BITS  = 40,
	parameter int DATA_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [ksl_pkg::OP_W-1:0]           req_type,
	input  wire logic [KEY_BITS-1:0]                key,
	input  wire logic [ksl_pkg::POS_W-1:0]          position,
	input  wire logic [DATA_BITS-1:0]               payload,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ksl_pkg::STATUS_W-1:0]            status,
	output logic [ksl_pkg::POS_W-1:0]               found_position,
	output logic [ksl_pkg::OUT_DATA_W-1:0]          found_payload,
	output logic [ksl_pkg::POS_W-1:0]               entry_count
);

	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int CMPW   = ((CW > ksl_pkg::POS_W) ? CW : ksl_pkg::POS_W) + 1;
	localparam int PW     = (DATA_BITS > ksl_pkg::OUT_DATA_W) ? DATA_BITS : ksl_pkg::OUT_DATA_W;
	localparam int WORD_W = KEY_BITS + DATA_BITS;

	ksl_pkg::state_t state_q, state_d;

	// request and working registers
	ksl_pkg::op_t                     op_q;
	logic [KEY_BITS-1:0]              key_q;
	logic [ksl_pkg::POS_W-1:0]        pos_q;
	logic [DATA_BITS-1:0]             pay_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    scan_q;
	logic                             hit_q;
	logic [AW-1:0]                    hit_idx_q;
	logic [DATA_BITS-1:0]             hit_pay_q;
	logic [CW-1:0]                    src_q;
	logic [CW-1:0]                    mv_q;
	ksl_pkg::status_t                 res_status_q;
	logic [ksl_pkg::POS_W-1:0]        res_pos_q;
	logic [ksl_pkg::OUT_DATA_W-1:0]   res_pay_q;

	// output register
	logic                             out_valid_q;
	logic [ksl_pkg::STATUS_W-1:0]     status_q;
	logic [ksl_pkg::POS_W-1:0]        found_pos_q;
	logic [ksl_pkg::OUT_DATA_W-1:0]   found_pay_q;
	logic [ksl_pkg::POS_W-1:0]        entry_count_q;

	// memory port
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_vld;
	logic [AW-1:0]     rd_idx;
	logic [WORD_W-1:0] rd_data;

	logic [KEY_BITS-1:0]  rd_key;
	logic [DATA_BITS-1:0] rd_pay;
	logic                 match;
	logic                 load_out;

	logic [CMPW-1:0] count_x;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] ins_idx_x;
	logic [CMPW-1:0] hit_pos_x;
	logic [PW-1:0]   hit_pay_x;
	logic [PW-1:0]   new_pay_x;

	ksl_pkg::status_t                d_status;
	logic [ksl_pkg::POS_W-1:0]       d_pos;
	logic [ksl_pkg::OUT_DATA_W-1:0]  d_pay;
	logic [CW-1:0]                   d_moves;
	logic [CW-1:0]                   d_src;

	ksl_store #(
		.DEPTH  (DEPTH),
		.WORD_W (WORD_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_vld  (rd_vld),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	assign rd_key = rd_data[WORD_W-1:DATA_BITS];
	assign rd_pay = rd_data[DATA_BITS-1:0];
	assign match  = rd_vld && (rd_key == key_q);

	assign count_x   = CMPW'(count_q);
	assign pos_x     = CMPW'(pos_q);
	assign ins_idx_x = pos_x - CMPW'(1);
	assign hit_pos_x = CMPW'(hit_idx_q) + CMPW'(1);
	assign hit_pay_x = PW'(hit_pay_q);
	assign new_pay_x = PW'(pay_q);

	// outcome of a request once the scan is over
	always_comb begin
		d_status = ksl_pkg::ST_OK;
		d_pos    = '0;
		d_pay    = '0;
		d_moves  = '0;
		d_src    = '0;
		case (op_q)
			ksl_pkg::OP_LOOKUP: begin
				if (hit_q) begin
					d_pos = hit_pos_x[ksl_pkg::POS_W-1:0];
					d_pay = hit_pay_x[ksl_pkg::OUT_DATA_W-1:0];
				end else begin
					d_status = ksl_pkg::ST_NOT_FOUND;
				end
			end
			ksl_pkg::OP_INSERT: begin
				if (hit_q) begin
					d_status = ksl_pkg::ST_DUPLICATE;
					d_pos    = hit_pos_x[ksl_pkg::POS_W-1:0];
					d_pay    = hit_pay_x[ksl_pkg::OUT_DATA_W-1:0];
				end else if (count_q == CW'(DEPTH)) begin
					d_status = ksl_pkg::ST_FULL;
				end else if (pos_q == '0 || pos_x > count_x + CMPW'(1)) begin
					d_status = ksl_pkg::ST_BAD_POS;
				end else begin
					d_pos   = pos_q;
					d_pay   = new_pay_x[ksl_pkg::OUT_DATA_W-1:0];
					// entries from the insert point up to the end move up by one
					d_moves = count_q - ins_idx_x[CW-1:0];
					d_src   = count_q - CW'(1);
				end
			end
			ksl_pkg::OP_UPDATE: begin
				if (hit_q) begin
					d_pos = hit_pos_x[ksl_pkg::POS_W-1:0];
					d_pay = new_pay_x[ksl_pkg::OUT_DATA_W-1:0];
				end else begin
					d_status = ksl_pkg::ST_NOT_FOUND;
				end
			end
			ksl_pkg::OP_DELETE: begin
				if (hit_q) begin
					d_pos   = hit_pos_x[ksl_pkg::POS_W-1:0];
					d_pay   = hit_pay_x[ksl_pkg::OUT_DATA_W-1:0];
					d_moves = count_q - CW'(hit_idx_q) - CW'(1);
					d_src   = CW'(hit_idx_q) + CW'(1);
				end else begin
					d_status = ksl_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				d_status = ksl_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and memory port control
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_data;
		load_out = 1'b0;
		case (state_q)
			ksl_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ksl_pkg::S_SCAN;
				end
			end
			ksl_pkg::S_SCAN: begin
				rd_en   = (scan_q < count_q) && !match;
				rd_addr = scan_q[AW-1:0];
				if (match || (scan_q >= count_q && !rd_vld)) begin
					state_d = ksl_pkg::S_DECIDE;
				end
			end
			ksl_pkg::S_DECIDE: begin
				if (d_moves != '0) begin
					state_d = ksl_pkg::S_SHIFT;
				end else begin
					state_d = ksl_pkg::S_FINAL;
				end
			end
			ksl_pkg::S_SHIFT: begin
				// read one entry, write it one slot over on the following cycle
				rd_en   = (mv_q != '0);
				rd_addr = src_q[AW-1:0];
				wr_en   = rd_vld;
				wr_data = rd_data;
				if (op_q == ksl_pkg::OP_INSERT) begin
					wr_addr = rd_idx + AW'(1);
				end else begin
					wr_addr = rd_idx - AW'(1);
				end
				if (mv_q == '0 && !rd_vld) begin
					state_d = ksl_pkg::S_FINAL;
				end
			end
			ksl_pkg::S_FINAL: begin
				wr_en   = (res_status_q == ksl_pkg::ST_OK) &&
					(op_q == ksl_pkg::OP_INSERT || op_q == ksl_pkg::OP_UPDATE);
				wr_data = {key_q, pay_q};
				if (op_q == ksl_pkg::OP_INSERT) begin
					wr_addr = ins_idx_x[AW-1:0];
				end else begin
					wr_addr = hit_idx_q;
				end
				state_d = ksl_pkg::S_DONE;
			end
			ksl_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ksl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ksl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ksl_pkg::S_FINAL && res_status_q == ksl_pkg::ST_OK) begin
				if (op_q == ksl_pkg::OP_INSERT) begin
					count_q <= count_q + CW'(1);
				end else if (op_q == ksl_pkg::OP_DELETE) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ksl_pkg::S_IDLE: begin
				if (in_valid) begin
					op_q   <= ksl_pkg::op_t'(req_type);
					key_q  <= key;
					pos_q  <= position;
					pay_q  <= payload;
					scan_q <= '0;
					hit_q  <= 1'b0;
				end
			end
			ksl_pkg::S_SCAN: begin
				if (rd_en) begin
					scan_q <= scan_q + CW'(1);
				end
				if (match) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx;
					hit_pay_q <= rd_pay;
				end
			end
			ksl_pkg::S_DECIDE: begin
				res_status_q <= d_status;
				res_pos_q    <= d_pos;
				res_pay_q    <= d_pay;
				mv_q         <= d_moves;
				src_q        <= d_src;
			end
			ksl_pkg::S_SHIFT: begin
				if (rd_en) begin
					mv_q <= mv_q - CW'(1);
					if (op_q == ksl_pkg::OP_INSERT) begin
						src_q <= src_q - CW'(1);
					end else begin
						src_q <= src_q + CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			status_q      <= res_status_q;
			found_pos_q   <= res_pos_q;
			found_pay_q   <= res_pay_q;
			entry_count_q <= count_x[ksl_pkg::POS_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_position = found_pos_q;
	assign found_payload  = found_pay_q;
	assign entry_count    = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ksl_pkg::S_SHIFT || state_q == ksl_pkg::S_FINAL))
		else $error("memory write outside shift or final phase");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ksl_pkg::S_FINAL && res_status_q == ksl_pkg::ST_OK &&
		 op_q == ksl_pkg::OP_INSERT) |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ksl_pkg::S_FINAL && res_status_q == ksl_pkg::ST_OK &&
		 op_q == ksl_pkg::OP_DELETE) |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink the list");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ksl_pkg::S_DONE))
		else $error("result presented without a finished request");

endmodule

`default_nettype wire
